[rtl/assert_macros.svh]
// Assertion macros shared by the percent escape codec modules.
// Every check samples on the rising clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a property on the same edge
`define PEC_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

[rtl/pec_pkg.sv]
// Package for the percent escape codec: mode codes, the queued job record
// and the character classification functions. No dependencies.
`timescale 1ns / 1ps

package pec_pkg;

   // Codec mode register codes
   localparam logic [1:0] MODE_DECODE       = 2'd0;
   localparam logic [1:0] MODE_ENC_STRICT   = 2'd1;
   localparam logic [1:0] MODE_ENC_SPACE    = 2'd2;
   localparam logic [1:0] MODE_ENC_SLASH    = 2'd3;

   // Escape phase codes of the decoder
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   localparam logic [7:0] PCT_CHAR    = 8'h25;
   localparam int         QUEUE_DEPTH = 2;

   // One queued job: up to three result characters
   typedef struct packed {
      logic [1:0] num;          // number of results, 1 to 3
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
      logic       final_valid;  // out_valid of the final result
      logic       final_last;   // out_last of the final result
   } job_type;

   // Hex digit value, top bit set when the character is a digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Lowercase hex character of a nibble
   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = 8'h30 + {4'd0, n};
      end else begin
         r = 8'h57 + {4'd0, n};
      end
      return r;
   endfunction

   // Characters that an encode mode passes unchanged
   function automatic logic passes_plain(input logic [7:0] c, input logic [1:0] mode);
      logic r;
      r = 1'b0;
      if (c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]}) begin
         r = 1'b1;
      end else if (c inside {8'h2a, 8'h2d, 8'h5f, 8'h2e, 8'h7e}) begin
         r = 1'b1;
      end else if (mode == MODE_ENC_SPACE && c == 8'h20) begin
         r = 1'b1;
      end else if (mode == MODE_ENC_SLASH && c == 8'h2f) begin
         r = 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/pec_front.sv]
// Front end of the percent escape codec: accepts request bytes, tracks the
// escape state and turns each request into a job record. Uses pec_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pec_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             job_valid,
   input  logic             job_ready,
   output pec_pkg::job_type job_data
);

   logic [1:0] mode_ff, mode_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       emit;
   logic [4:0] hi_dig, lo_dig;
   logic [7:0] dec_val;
   pec_pkg::job_type job;

   assign csr_ready  = 1'b1;
   assign req_tready = job_ready;
   assign accept     = req_tvalid & req_tready;
   assign job_valid  = accept & emit;
   assign job_data   = job;

   assign hi_dig = pec_pkg::hex_digit(held_ff);
   assign lo_dig = pec_pkg::hex_digit(req_tdata);

   // Value of an escape: stop reading at the first non-digit
   always_comb begin
      dec_val = 8'd0;
      if (hi_dig[4]) begin
         dec_val = lo_dig[4] ? {hi_dig[3:0], lo_dig[3:0]} : {4'd0, hi_dig[3:0]};
      end
   end

   // Classify the request and build its job
   always_comb begin
      phase_in        = phase_ff;
      held_in         = held_ff;
      emit            = 1'b1;
      job.num         = 2'd1;
      job.ch0         = req_tdata;
      job.ch1         = req_tdata;
      job.ch2         = req_tdata;
      job.final_valid = 1'b1;
      job.final_last  = req_tlast;
      if (mode_ff != pec_pkg::MODE_DECODE) begin
         phase_in = pec_pkg::PHASE_IDLE;
         if (!pec_pkg::passes_plain(req_tdata, mode_ff)) begin
            job.num = 2'd3;
            job.ch0 = pec_pkg::PCT_CHAR;
            job.ch1 = pec_pkg::nibble_char(req_tdata[7:4]);
            job.ch2 = pec_pkg::nibble_char(req_tdata[3:0]);
         end
      end else begin
         case (phase_ff)
            pec_pkg::PHASE_PCT: begin
               if (req_tlast) begin
                  phase_in = pec_pkg::PHASE_IDLE;
                  job.num  = 2'd2;
                  job.ch0  = pec_pkg::PCT_CHAR;
               end else begin
                  held_in  = req_tdata;
                  phase_in = pec_pkg::PHASE_DIGIT;
                  emit     = 1'b0;
               end
            end
            pec_pkg::PHASE_DIGIT: begin
               phase_in = pec_pkg::PHASE_IDLE;
               job.ch0  = dec_val;
               if (dec_val == 8'd0) begin
                  // Drop a zero escape; close the string with an empty marker
                  job.final_valid = 1'b0;
                  emit            = req_tlast;
               end
            end
            default: begin
               phase_in = pec_pkg::PHASE_IDLE;
               if (req_tdata == pec_pkg::PCT_CHAR && !req_tlast) begin
                  phase_in = pec_pkg::PHASE_PCT;
                  emit     = 1'b0;
               end
            end
         endcase
      end
   end

   // Mode write clears any partial escape
   assign mode_in = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pec_pkg::MODE_DECODE;
         phase_ff <= pec_pkg::PHASE_IDLE;
         held_ff  <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         mode_ff  <= mode_in;
         phase_ff <= pec_pkg::PHASE_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   `PEC_ASSERT_IMPL(a_phase_only_decode, phase_ff != pec_pkg::PHASE_IDLE,
      mode_ff == pec_pkg::MODE_DECODE, "escape phase open outside decode mode")

endmodule

[rtl/pec_queue.sv]
// Short job queue between the codec front and back ends, built from
// registers with head and tail pointers. Uses pec_pkg for the job record.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pec_queue #(
   parameter int DEPTH = pec_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pec_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pec_pkg::job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pec_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Advance pointers with wrap and track the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the job payload
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PEC_ASSERT(a_count_bound, count_ff <= CNT_FULL, "queue fill count above depth")
   `PEC_ASSERT_IMPL(a_ptr_match, (count_ff == '0) || (count_ff == CNT_FULL),
      wr_ptr_ff == rd_ptr_ff, "queue pointers apart while empty or full")

endmodule

[rtl/pec_back.sv]
// Codec back end (job record from pec_pkg): walks the head job one result
// per cycle into a registered response stage unless the receiver stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pec_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  pec_pkg::job_type job_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_final;

   assign load      = job_valid & (~valid_ff | rsp_tready);
   assign is_final  = (idx_ff == job_data.num - 2'd1);
   assign job_ready = load & is_final;

   // Select the current result of the head job
   always_comb begin
      case (idx_ff)
         2'd0:    data_in = job_data.ch0;
         2'd1:    data_in = job_data.ch1;
         default: data_in = job_data.ch2;
      endcase
      user_in  = is_final ? job_data.final_valid : 1'b1;
      last_in  = is_final ? job_data.final_last : 1'b0;
      idx_in   = load ? (is_final ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load | (valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `PEC_ASSERT_IMPL(a_idx_in_job, job_valid, idx_ff < job_data.num,
      "result index past the head job")

endmodule

[rtl/percent_escape_codec.sv]
// Percent escape codec top level: front end, job queue and back end.
// Depends on pec_pkg, pec_front, pec_queue and pec_back.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : input string, one byte per request, tlast on the final byte.
//   rsp_*  : output characters; tuser is 1 for a real character and 0 for an
//            empty end marker (tdata 0, tlast 1); tlast marks the final result.
//   csr_*  : writes the 2-bit mode (0 decode, 1 encode strict, 2 encode keeping
//            space, 3 encode keeping slash); write only while the block is idle.
//            A write drops any partial escape.
// Path: an accepted request passes through the job queue and then the
//   registered response stage before its result appears.
// Throughput: the back end sends one result per cycle while the receiver is
//   ready, so an encoded escape gives three results per byte, a short escape
//   at the end two, other bytes one. Requests that give no result (the '%'
//   and first digit of an escape) are taken at the front end without a job.
// The job queue (QUEUE_DEPTH entries) lets the front end keep accepting
//   requests while the back end drains a multi-character job.
// Reset: synchronous; clears the mode to decode, the escape state and the
//   queue. A stalled receiver holds the response register; once the queue
//   fills, req_tready drops.
//
module percent_escape_codec #(
   parameter int QUEUE_DEPTH = pec_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data,     // codec_mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tuser,    // [0] out_valid
   output logic       rsp_tlast
);

   logic             fq_valid, fq_ready;
   pec_pkg::job_type fq_data;
   logic             qb_valid, qb_ready;
   pec_pkg::job_type qb_data;

   // Classify requests
   pec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job_data   (fq_data)
   );

   // Buffer jobs between the two ends
   pec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Emit results
   pec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job_data   (qb_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
